@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/wmts_pkg.sv @@
`default_nettype none

package wmts_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] REG_OP_KIND            = 3'd0;
   localparam logic [2:0] REG_BATCH_SIZE         = 3'd1;
   localparam logic [2:0] REG_SPATIAL_TOTAL      = 3'd2;
   localparam logic [2:0] REG_M_TILE_SIZE        = 3'd3;
   localparam logic [2:0] REG_N_TILE_SIZE        = 3'd4;
   localparam logic [2:0] REG_GROUP_COUNT        = 3'd5;
   localparam logic [2:0] REG_CHANNELS_PER_GROUP = 3'd6;
   localparam logic [2:0] REG_REDUCTION_DEPTH    = 3'd7;

   localparam int CSR_DATA_W = 17;

   // Layer mode
   localparam logic OP_CONV   = 1'b0;
   localparam logic OP_LINEAR = 1'b1;

   typedef struct packed {
      logic        op_kind;
      logic [8:0]  batch_size;
      logic [16:0] spatial_total;
      logic [12:0] m_tile_size;
      logic [10:0] n_tile_size;
      logic [4:0]  group_count;
      logic [12:0] channels_per_group;
      logic [15:0] reduction_depth;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  tile_group;
      logic [15:0] chan_base;
      logic [10:0] chan_count;
      logic [7:0]  batch_first;
      logic [8:0]  batch_span;
      logic [15:0] spatial_first;
      logic [12:0] spatial_span;
      logic [15:0] depth_out;
      logic        first_of_weights;
      logic        last_of_weights;
      logic        last_of_schedule;
   } tile_type;

endpackage

`default_nettype wire

@@ rtl/wmts_cfg.sv @@
`default_nettype none

module wmts_cfg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [2:0]                     csr_index,
   input  wire logic [wmts_pkg::CSR_DATA_W-1:0] csr_wdata,
   output wmts_pkg::cfg_type                   cfg
);
   import wmts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic [8:0]  bs_raw;
   logic [12:0] m_raw;
   logic [10:0] n_raw;
   logic [4:0]  g_raw;
   logic [12:0] cpg_raw;
   logic [15:0] k_raw;

   // Clamp each written value into its legal range
   always_comb begin
      bs_raw  = csr_wdata[8:0];
      m_raw   = csr_wdata[12:0];
      n_raw   = csr_wdata[10:0];
      g_raw   = csr_wdata[4:0];
      cpg_raw = csr_wdata[12:0];
      k_raw   = csr_wdata[15:0];
      cfg_in  = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_OP_KIND: begin
               cfg_in.op_kind = csr_wdata[0];
            end
            REG_BATCH_SIZE: begin
               cfg_in.batch_size = (bs_raw == 9'd0) ? 9'd1 :
                                   (bs_raw > 9'd256) ? 9'd256 : bs_raw;
            end
            REG_SPATIAL_TOTAL: begin
               cfg_in.spatial_total = (csr_wdata == 17'd0) ? 17'd1 :
                                      (csr_wdata > 17'd65536) ? 17'd65536 : csr_wdata;
            end
            REG_M_TILE_SIZE: begin
               cfg_in.m_tile_size = (m_raw == 13'd0) ? 13'd1 :
                                    (m_raw > 13'd4096) ? 13'd4096 : m_raw;
            end
            REG_N_TILE_SIZE: begin
               cfg_in.n_tile_size = (n_raw == 11'd0) ? 11'd1 :
                                    (n_raw > 11'd1024) ? 11'd1024 : n_raw;
            end
            REG_GROUP_COUNT: begin
               cfg_in.group_count = (g_raw == 5'd0) ? 5'd1 :
                                    (g_raw > 5'd16) ? 5'd16 : g_raw;
            end
            REG_CHANNELS_PER_GROUP: begin
               cfg_in.channels_per_group = (cpg_raw == 13'd0) ? 13'd1 :
                                           (cpg_raw > 13'd4096) ? 13'd4096 : cpg_raw;
            end
            REG_REDUCTION_DEPTH: begin
               cfg_in.reduction_depth = (k_raw == 16'd0) ? 16'd1 : k_raw;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Hold the register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.op_kind            <= OP_CONV;
         cfg_ff.batch_size         <= 9'd1;
         cfg_ff.spatial_total      <= 17'd1;
         cfg_ff.m_tile_size        <= 13'd1;
         cfg_ff.n_tile_size        <= 11'd1;
         cfg_ff.group_count        <= 5'd1;
         cfg_ff.channels_per_group <= 13'd1;
         cfg_ff.reduction_depth    <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/wmts_sched.sv @@
`default_nettype none
`include "assert_macros.svh"

module wmts_sched (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              restart,
   input  wire wmts_pkg::cfg_type cfg,
   output logic                   produce,
   output wmts_pkg::tile_type     tile
);
   import wmts_pkg::*;

   logic [3:0]  group_ff, group_in;
   logic [11:0] chan_ff, chan_in;
   logic [7:0]  batch_ff, batch_in;
   logic [15:0] spatial_ff, spatial_in;
   logic        finished_ff, finished_in;

   logic [3:0]  eff_group;
   logic [11:0] eff_chan;
   logic [7:0]  eff_batch;
   logic [15:0] eff_spatial;
   logic        eff_finished;
   logic        linear;
   logic [3:0]  grp;
   logic [16:0] grp_prod;
   logic [12:0] left_c;
   logic [12:0] chan_sum;
   logic        chan_wrap;
   logic [8:0]  left_b;
   logic [13:0] nb;
   logic [16:0] left_s;
   logic [16:0] ns;
   logic [8:0]  bc_inc;
   logic [4:0]  gc_inc;
   logic        lin_last_w;
   logic        conv_batch_last;
   logic        conv_spatial_last;
   logic        group_last;

   // Work out the current tile and the next loop position
   always_comb begin
      eff_group    = restart ? 4'd0 : group_ff;
      eff_chan     = restart ? 12'd0 : chan_ff;
      eff_batch    = restart ? 8'd0 : batch_ff;
      eff_spatial  = restart ? 16'd0 : spatial_ff;
      eff_finished = restart ? 1'b0 : finished_ff;
      produce      = !eff_finished;
      linear       = (cfg.op_kind == OP_LINEAR);

      grp      = linear ? 4'd0 : eff_group;
      grp_prod = 17'(grp) * 17'(cfg.channels_per_group);

      // Channel clip and wrap
      left_c    = (cfg.channels_per_group > {1'b0, eff_chan}) ?
                  cfg.channels_per_group - {1'b0, eff_chan} : 13'd1;
      chan_sum  = {1'b0, eff_chan} + {2'b0, cfg.n_tile_size};
      chan_wrap = (chan_sum >= cfg.channels_per_group);

      // Batch chunk (linear)
      left_b     = (cfg.batch_size > {1'b0, eff_batch}) ?
                   cfg.batch_size - {1'b0, eff_batch} : 9'd1;
      nb         = {6'b0, eff_batch} + {1'b0, cfg.m_tile_size};
      lin_last_w = (nb >= {5'b0, cfg.batch_size});

      // Spatial chunk and batch image (convolution)
      left_s            = (cfg.spatial_total > {1'b0, eff_spatial}) ?
                          cfg.spatial_total - {1'b0, eff_spatial} : 17'd1;
      ns                = {1'b0, eff_spatial} + {4'b0, cfg.m_tile_size};
      bc_inc            = {1'b0, eff_batch} + 9'd1;
      gc_inc            = {1'b0, eff_group} + 5'd1;
      conv_spatial_last = (ns >= cfg.spatial_total);
      conv_batch_last   = (bc_inc >= cfg.batch_size);
      group_last        = (gc_inc >= cfg.group_count);

      tile.tile_group  = grp;
      tile.chan_base   = grp_prod[15:0] + {4'b0, eff_chan};
      tile.chan_count  = ({2'b0, cfg.n_tile_size} < left_c) ? cfg.n_tile_size
                                                            : left_c[10:0];
      tile.batch_first = eff_batch;
      tile.depth_out   = cfg.reduction_depth;

      if (linear) begin
         tile.batch_span       = (cfg.m_tile_size < {4'b0, left_b}) ?
                                 cfg.m_tile_size[8:0] : left_b;
         tile.spatial_first    = 16'd0;
         tile.spatial_span     = 13'd1;
         tile.first_of_weights = (eff_batch == 8'd0);
         tile.last_of_weights  = lin_last_w;
         tile.last_of_schedule = lin_last_w && chan_wrap;
      end else begin
         tile.batch_span       = 9'd1;
         tile.spatial_first    = eff_spatial;
         tile.spatial_span     = ({4'b0, cfg.m_tile_size} < left_s) ?
                                 cfg.m_tile_size : left_s[12:0];
         tile.first_of_weights = (eff_batch == 8'd0) && (eff_spatial == 16'd0);
         tile.last_of_weights  = conv_batch_last && conv_spatial_last;
         tile.last_of_schedule = conv_batch_last && conv_spatial_last && chan_wrap &&
                                 group_last;
      end

      // Advance the loop nest
      group_in    = eff_group;
      chan_in     = eff_chan;
      batch_in    = eff_batch;
      spatial_in  = eff_spatial;
      finished_in = eff_finished;
      if (produce) begin
         if (linear) begin
            if (lin_last_w) begin
               batch_in = 8'd0;
               if (chan_wrap) begin
                  chan_in     = 12'd0;
                  finished_in = 1'b1;
               end else begin
                  chan_in = chan_sum[11:0];
               end
            end else begin
               batch_in = nb[7:0];
            end
         end else begin
            if (conv_spatial_last) begin
               spatial_in = 16'd0;
               if (conv_batch_last) begin
                  batch_in = 8'd0;
                  if (chan_wrap) begin
                     chan_in = 12'd0;
                     if (group_last) begin
                        group_in    = 4'd0;
                        finished_in = 1'b1;
                     end else begin
                        group_in = gc_inc[3:0];
                     end
                  end else begin
                     chan_in = chan_sum[11:0];
                  end
               end else begin
                  batch_in = bc_inc[7:0];
               end
            end else begin
               spatial_in = ns[15:0];
            end
         end
      end
   end

   // Hold loop counters; step once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff    <= 4'd0;
         chan_ff     <= 12'd0;
         batch_ff    <= 8'd0;
         spatial_ff  <= 16'd0;
         finished_ff <= 1'b1;
      end else if (advance) begin
         group_ff    <= group_in;
         chan_ff     <= chan_in;
         batch_ff    <= batch_in;
         spatial_ff  <= spatial_in;
         finished_ff <= finished_in;
      end
   end

   // Final tile must leave the block finished
   `ASSERT_NEXT(a_done_after_last, clock, reset,
                advance && produce && tile.last_of_schedule, finished_ff)
   // Counters only move on a processed beat
   `ASSERT_NEXT(a_hold_when_idle, clock, reset, !advance,
                $stable(chan_ff) && $stable(batch_ff) && $stable(group_ff))
   // A finished schedule rests at the start of its channel and batch loops
   `ASSERT_SAME(a_finished_at_origin, clock, reset, finished_ff,
                (chan_ff == 12'd0) && (batch_ff == 8'd0))

endmodule

`default_nettype wire

@@ rtl/weight_major_tile_scheduler.sv @@
// A request waits in the input register until the result register is free or draining, then its tile
// is registered there and shown on rsp_valid. Throughput: one request per cycle while rsp_ready does
// not stall; the loop counters step once per processed beat. Input register and result register let
// a request be taken while a tile waits on rsp_ready. A request without restart while the schedule is
// finished gives no tile and leaves the state alone. Reset (synchronous, active high) clears both
// valid flags, zeroes the counters, marks the schedule finished and loads the configuration defaults.
`default_nettype none
`include "assert_macros.svh"

module weight_major_tile_scheduler (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_restart,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [3:0]                          rsp_tile_group,
   output logic [15:0]                         rsp_chan_base,
   output logic [10:0]                         rsp_chan_count,
   output logic [7:0]                          rsp_batch_first,
   output logic [8:0]                          rsp_batch_span,
   output logic [15:0]                         rsp_spatial_first,
   output logic [12:0]                         rsp_spatial_span,
   output logic [15:0]                         rsp_depth_out,
   output logic                                rsp_first_of_weights,
   output logic                                rsp_last_of_weights,
   output logic                                rsp_last_of_schedule,
   input  wire logic                           csr_write_en,
   input  wire logic [2:0]                     csr_index,
   input  wire logic [wmts_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wmts_pkg::*;

   cfg_type  cfg;
   tile_type tile;
   tile_type rsp_data_ff;
   logic     produce;
   logic     advance;
   logic     in_valid_ff, in_valid_in;
   logic     in_restart_ff;
   logic     rsp_valid_ff, rsp_valid_in;

   wmts_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   wmts_sched u_sched (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .restart (in_restart_ff),
      .cfg     (cfg),
      .produce (produce),
      .tile    (tile)
   );

   // Process the held beat when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      rsp_valid_in = advance ? produce : (rsp_valid_ff && !rsp_ready);
   end

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_restart_ff <= req_restart;
      end
      if (advance && produce) begin
         rsp_data_ff <= tile;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_tile_group       = rsp_data_ff.tile_group;
   assign rsp_chan_base        = rsp_data_ff.chan_base;
   assign rsp_chan_count       = rsp_data_ff.chan_count;
   assign rsp_batch_first      = rsp_data_ff.batch_first;
   assign rsp_batch_span       = rsp_data_ff.batch_span;
   assign rsp_spatial_first    = rsp_data_ff.spatial_first;
   assign rsp_spatial_span     = rsp_data_ff.spatial_span;
   assign rsp_depth_out        = rsp_data_ff.depth_out;
   assign rsp_first_of_weights = rsp_data_ff.first_of_weights;
   assign rsp_last_of_weights  = rsp_data_ff.last_of_weights;
   assign rsp_last_of_schedule = rsp_data_ff.last_of_schedule;

   // A processed beat shows a tile next cycle exactly when it produced one
   `ASSERT_NEXT(a_rsp_follows_produce, clock, reset, advance, rsp_valid_ff == $past(produce))
   // A held request is never dropped while the result side stalls
   `ASSERT_NEXT(a_req_kept_on_stall, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // A waiting tile beat keeps its valid and payload
   `ASSERT_NEXT(a_rsp_held_on_stall, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(rsp_data_ff))

endmodule

`default_nettype wire
